FILE: rtl/core/bsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsr_pkg;

	// Default geometry of the signed fixed-point operand
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Register and result field widths
	localparam int TOL_W      = 31;
	localparam int ITER_W     = 6;
	localparam int ROOT_W     = 24;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 31;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 1'd1;

	// Register reset values
	localparam logic [TOL_W-1:0]  TOL_RESET  = 31'd66;
	localparam logic [ITER_W-1:0] ITER_RESET = 6'd40;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NEGATIVE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TOL_ZERO = 2'd2;
	localparam logic [STATUS_W-1:0] ST_LIMIT    = 2'd3;

	localparam logic [ROOT_W-1:0] ROOT_MAX = 24'hFF_FFFF;

	// Handshake between sequencer and squaring unit
	typedef struct packed {
		logic start;
	} sq_ctrl_t;

	typedef struct packed {
		logic done;
	} sq_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/bsr_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Operand request channel
interface bsr_in_if import bsr_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] value_in;

	modport source (output valid, output value_in, input ready);
	modport sink   (input valid, input value_in, output ready);
endinterface

// Result request channel
interface bsr_out_if import bsr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ROOT_W-1:0]   root;
	logic [STATUS_W-1:0] status;
	logic [ITER_W-1:0]   iterations_used;

	modport source (output valid, output root, output status, output iterations_used,
		input ready);
	modport sink   (input valid, input root, input status, input iterations_used,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bsr_squarer.sv
`timescale 1ns / 1ps
`default_nettype none

// Squares y with one half-width multiplier over three partial products.
module bsr_squarer import bsr_pkg::*; #(
	parameter int Y_W = DATA_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire sq_ctrl_t                        ctrl,
	input  wire logic [Y_W-1:0]                  y,
	output      logic [4*((Y_W + 1) / 2)-1:0]    sq,
	output      sq_stat_t                        stat
);

	localparam int HALF_W = (Y_W + 1) / 2;
	localparam int PROD_W = 2 * HALF_W;
	localparam int SQ_W   = 4 * HALF_W;

	localparam logic [1:0] SQ_IDLE  = 2'd0;
	localparam logic [1:0] SQ_CROSS = 2'd1;
	localparam logic [1:0] SQ_HIGH  = 2'd2;
	localparam logic [1:0] SQ_LAST  = 2'd3;

	logic [1:0]        state_q;
	logic              done_q;
	logic [PROD_W-1:0] prod_q;
	logic [SQ_W-1:0]   acc_q;
	logic [HALF_W-1:0] y_lo;
	logic [HALF_W-1:0] y_hi;
	logic [HALF_W-1:0] op_a;
	logic [HALF_W-1:0] op_b;
	logic [SQ_W-1:0]   prod_ext;

	assign y_lo     = y[HALF_W-1:0];
	assign y_hi     = HALF_W'(y[Y_W-1:HALF_W]);
	// lo*lo first, then hi*lo, then hi*hi
	assign op_a     = (state_q == SQ_IDLE) ? y_lo : y_hi;
	assign op_b     = (state_q == SQ_HIGH) ? y_hi : y_lo;
	assign prod_ext = {{PROD_W{1'b0}}, prod_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				SQ_IDLE: begin
					if (ctrl.start) begin
						state_q <= SQ_CROSS;
					end
				end
				SQ_CROSS: state_q <= SQ_HIGH;
				SQ_HIGH:  state_q <= SQ_LAST;
				SQ_LAST: begin
					state_q <= SQ_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= SQ_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		unique case (state_q)
			SQ_CROSS: acc_q <= prod_ext;
			SQ_HIGH:  acc_q <= acc_q + (prod_ext << (HALF_W + 1));
			SQ_LAST:  acc_q <= acc_q + (prod_ext << (2 * HALF_W));
			default:  acc_q <= acc_q;
		endcase
	end

	assign sq        = acc_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

FILE: rtl/core/bisection_square_root.sv
`timescale 1ns / 1ps
`default_nettype none

// Negative, zero-tolerance, zero and one-point-zero inputs go straight to the result;
//   others try midpoints until the tolerance is met or the cap ends the search,
//   at most max_iterations midpoints in all.
// Each midpoint takes a midpoint add, the partial products on the squaring multiplier, a compare.
// No new request is taken while one is in progress; a new request is taken once the previous
//   result sits in the output register. arst_n clears control and restores registers.
module bisection_square_root import bsr_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	bsr_in_if.sink                     operand,
	bsr_out_if.source                  result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// Interval bounds must also hold 1.0 when the format has no integer bits
	localparam int Y_W    = (DATA_WIDTH > FRAC_BITS) ? DATA_WIDTH : FRAC_BITS + 1;
	localparam int SQ_W   = 4 * ((Y_W + 1) / 2);
	// Compare width: holds the square, x*2^F and tolerance*2^F
	localparam int CMP_W  = ((SQ_W > 32) ? SQ_W : 32) + FRAC_BITS;
	localparam logic [Y_W-1:0] ONE_Y = Y_W'(1) << FRAC_BITS;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MID  = 2'd1;
	localparam logic [1:0] S_SQR  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	// Registers
	logic [TOL_W-1:0]  tol_q;
	logic [ITER_W-1:0] cap_q;

	// Sequencer
	logic [1:0]            state_q;
	logic                  start_q;
	logic [DATA_WIDTH-1:0] raw_q;
	logic [Y_W-1:0]        lo_q;
	logic [Y_W-1:0]        hi_q;
	logic [Y_W-1:0]        y_q;
	logic [ITER_W-1:0]     cnt_q;
	logic [STATUS_W-1:0]   status_q;

	// Output register
	logic                  out_valid_q;
	logic [ROOT_W-1:0]     root_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [ITER_W-1:0]     out_iter_q;

	logic [DATA_WIDTH-1:0] raw;
	logic [Y_W-1:0]        raw_y;
	logic                  take;
	logic [Y_W:0]          mid_sum;
	logic [Y_W-1:0]        mid;
	sq_ctrl_t              sq_ctrl;
	sq_stat_t              sq_stat;
	logic [SQ_W-1:0]       sq;
	logic [CMP_W-1:0]      sq_c;
	logic [CMP_W-1:0]      xs_c;
	logic [CMP_W-1:0]      tl_c;
	logic [CMP_W-1:0]      err_c;
	logic [CMP_W-1:0]      y_c;
	logic [ROOT_W-1:0]     root_sat;
	logic                  load_out;

	assign raw   = operand.value_in;
	assign raw_y = Y_W'(raw);
	assign take  = operand.valid && operand.ready;

	assign operand.ready = (state_q == S_IDLE);

	// Floor midpoint of the current interval
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[Y_W:1];

	assign sq_ctrl.start = start_q;

	bsr_squarer #(
		.Y_W (Y_W)
	) u_squarer (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (sq_ctrl),
		.y      (y_q),
		.sq     (sq),
		.stat   (sq_stat)
	);

	// Exact error |y*y - x| against tolerance, all in Q.2F
	assign sq_c  = CMP_W'(sq);
	assign xs_c  = CMP_W'(raw_q) << FRAC_BITS;
	assign tl_c  = CMP_W'(tol_q) << FRAC_BITS;
	assign err_c = (sq_c >= xs_c) ? (sq_c - xs_c) : (xs_c - sq_c);

	// Root above 24 bits only on a capped search; saturate it
	assign y_c      = CMP_W'(y_q);
	assign root_sat = (y_c > CMP_W'(ROOT_MAX)) ? ROOT_MAX : y_c[ROOT_W-1:0];

	assign load_out = (state_q == S_DONE) && (!out_valid_q || result.ready);

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
			cap_q <= ITER_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TOLERANCE: tol_q <= cfg_data[TOL_W-1:0];
				REG_MAX_ITER:  cap_q <= cfg_data[ITER_W-1:0];
				default: ;
			endcase
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						// Special inputs go straight to the result
						if (raw[DATA_WIDTH-1] || tol_q == '0 || raw_y == '0 ||
							raw_y == ONE_Y) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_MID;
						end
					end
				end
				S_MID: begin
					if (cnt_q == cap_q) begin
						state_q <= S_DONE;
					end else begin
						start_q <= 1'b1;
						state_q <= S_SQR;
					end
				end
				S_SQR: begin
					if (sq_stat.done) begin
						state_q <= (err_c < tl_c) ? S_DONE : S_MID;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					raw_q    <= raw;
					cnt_q    <= '0;
					status_q <= ST_OK;
					y_q      <= '0;
					priority if (raw[DATA_WIDTH-1]) begin
						status_q <= ST_NEGATIVE;
					end else if (tol_q == '0) begin
						status_q <= ST_TOL_ZERO;
					end else if (raw_y == ONE_Y) begin
						y_q <= ONE_Y;
					end else if (raw_y > ONE_Y) begin
						lo_q <= ONE_Y;
						hi_q <= raw_y;
					end else begin
						lo_q <= '0;
						hi_q <= ONE_Y;
					end
				end
			end
			S_MID: begin
				if (cnt_q == cap_q) begin
					// Cap reached: keep last tried midpoint, or the first one if none
					status_q <= ST_LIMIT;
					if (cnt_q == '0) begin
						y_q <= mid;
					end
				end else begin
					y_q   <= mid;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			S_SQR: begin
				if (sq_stat.done && !(err_c < tl_c)) begin
					if (sq_c > xs_c) begin
						hi_q <= y_q;
					end else begin
						lo_q <= y_q;
					end
				end
			end
			default: ;
		endcase
		if (load_out) begin
			root_q       <= root_sat;
			out_status_q <= status_q;
			out_iter_q   <= cnt_q;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.root            = root_q;
	assign result.status          = out_status_q;
	assign result.iterations_used = out_iter_q;

endmodule

`default_nettype wire

FILE: rtl/core/bsr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bsr_checker import bsr_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [ROOT_W-1:0]     root,
	input wire logic [STATUS_W-1:0]   status,
	input wire logic [ITER_W-1:0]     iterations_used,
	input wire logic                  cfg_we,
	input wire logic [CFG_IDX_W-1:0]  cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [ITER_W-1:0] cap_q;

	// Shadow of the iteration cap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= ITER_RESET;
		end else if (cfg_we && cfg_index == REG_MAX_ITER) begin
			cap_q <= cfg_data[ITER_W-1:0];
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(root) && $stable(status) &&
			$stable(iterations_used))
		else $error("result dropped or changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous one in progress");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NEGATIVE || status == ST_TOL_ZERO) |->
			root == '0 && iterations_used == '0)
		else $error("error result carries root or iterations");

	a_limit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_LIMIT |-> iterations_used == cap_q)
		else $error("limit status without full iteration count");

	a_ok_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> iterations_used <= cap_q)
		else $error("iterations beyond cap");

endmodule

bind bisection_square_root bsr_checker u_bsr_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (operand.valid),
	.in_ready        (operand.ready),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.root            (result.root),
	.status          (result.status),
	.iterations_used (result.iterations_used),
	.cfg_we          (cfg_we),
	.cfg_index       (cfg_index),
	.cfg_data        (cfg_data)
);

`default_nettype wire

FILE: test/tb_bisection_square_root.sv
`timescale 1ns / 1ps

module tb_bisection_square_root;
	import bsr_pkg::*;

	// One finished answer: root, status code and midpoints tried
	typedef struct packed {
		logic [ROOT_W-1:0]   root;
		logic [STATUS_W-1:0] status;
		logic [ITER_W-1:0]   used;
	} root_answer_t;

	// Receiver stall modes
	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

	// Keeps its own copy of both registers, predicts each answer when the
	// operand request is taken and holds it until the matching result shows up.
	class root_tracker;
		logic [TOL_W-1:0]  tol_q16 = TOL_RESET;
		logic [ITER_W-1:0] iter_cap = ITER_RESET;
		root_answer_t      pending_roots[$];
		int unsigned       mismatches = 0;

		function void take_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_TOLERANCE) begin
				tol_q16 = data[TOL_W-1:0];
			end else if (idx == REG_MAX_ITER) begin
				iter_cap = data[ITER_W-1:0];
			end
		endfunction

		// Bisection on the Q16.16 operand, squared error kept exact in Q32.32
		function root_answer_t bisect_root(logic [31:0] raw);
			bit [63:0]    lo, hi, mid, sq, xs, tl, err;
			int unsigned  n;
			bit           hit;
			root_answer_t ans;
			ans = '0;
			if (raw[31]) begin
				ans.status = ST_NEGATIVE;
			end else if (tol_q16 == '0) begin
				ans.status = ST_TOL_ZERO;
			end else if (raw == 32'd0) begin
				ans.status = ST_OK;
			end else if (raw == ONE_Q16) begin
				ans.root   = ONE_Q16[ROOT_W-1:0];
				ans.status = ST_OK;
			end else begin
				xs = {32'd0, raw} << 16;
				tl = {33'd0, tol_q16} << 16;
				if (raw > ONE_Q16) begin
					lo = {32'd0, ONE_Q16};
					hi = {32'd0, raw};
				end else begin
					lo = 64'd0;
					hi = {32'd0, ONE_Q16};
				end
				// with a zero cap the starting midpoint is returned untested
				mid = (lo + hi) >> 1;
				n   = 0;
				hit = 1'b0;
				while (n < iter_cap && !hit) begin
					mid = (lo + hi) >> 1;
					n++;
					sq  = mid * mid;
					err = (sq >= xs) ? sq - xs : xs - sq;
					if (err < tl) begin
						hit = 1'b1;
					end else if (sq > xs) begin
						hi = mid;
					end else begin
						lo = mid;
					end
				end
				ans.root   = (mid > {40'd0, ROOT_MAX}) ? ROOT_MAX : mid[ROOT_W-1:0];
				ans.status = hit ? ST_OK : ST_LIMIT;
				ans.used   = n[ITER_W-1:0];
			end
			return ans;
		endfunction

		function void note_operand(logic [31:0] raw);
			pending_roots.push_back(bisect_root(raw));
		endfunction

		function void check_answer(logic [ROOT_W-1:0] root, logic [STATUS_W-1:0] status,
			logic [ITER_W-1:0] used);
			root_answer_t want;
			if (pending_roots.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result root=%h status=%0d iter=%0d",
						$time, root, status, used);
				return;
			end
			want = pending_roots.pop_front();
			if (want.root !== root || want.status !== status || want.used !== used) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: expected root=%h status=%0d iter=%0d, got root=%h status=%0d iter=%0d",
						$time, want.root, want.status, want.used, root, status, used);
			end
		endfunction

		function int unsigned outstanding();
			return pending_roots.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bsr_in_if #(.DATA_WIDTH(DATA_WIDTH_DEF)) req_if ();
	bsr_out_if res_if ();

	root_tracker roots = new;

	rx_mode_t    rx_mode = RX_OPEN;
	int unsigned rx_left = 0;
	int unsigned rx_beat = 0;

	bisection_square_root #(
		.DATA_WIDTH(DATA_WIDTH_DEF),
		.FRAC_BITS (FRAC_BITS_DEF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.operand  (req_if),
		.result   (res_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 20 ns period
	always #10 clk = ~clk;

	// Receiver back-pressure: it drifts between modes so stalls land on every
	// cycle of the block's work, with some long fully-open stretches.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(50, 400);
		end else begin
			rx_left--;
		end
		rx_beat++;
		case (rx_mode)
			RX_OPEN:   res_if.ready <= 1'b1;
			RX_COIN:   res_if.ready <= $urandom_range(0, 1);
			RX_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
			default:   res_if.ready <= (rx_beat % 5) < 2;
		endcase
	end

	// Result monitor; values read here are the ones before the edge
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			roots.check_answer(res_if.root, res_if.status, res_if.iterations_used);
	end

	// Called at a falling edge; returns at the falling edge after the request
	// is taken, with valid still high so a burst can carry straight on.
	task automatic send_operand(input logic [31:0] raw);
		req_if.valid    <= 1'b1;
		req_if.value_in <= raw;
		do @(posedge clk); while (!req_if.ready);
		roots.note_operand(raw);
		@(negedge clk);
	endtask

	// Register write, only ever issued with the block idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		roots.take_config(idx, data);
	endtask

	// Drop valid and wait for every predicted answer to come back
	task automatic drain();
		req_if.valid <= 1'b0;
		while (roots.outstanding() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_operand();
		logic [31:0] v;
		int unsigned k;
		case ($urandom_range(0, 9))
			0: v = $urandom;
			1: v = {1'b1, 31'($urandom)};
			2: v = $urandom_range(1, 32'h0000_FFFF);              // below 1.0
			3: v = $urandom_range(32'h0001_0001, 32'h0010_0000);  // 1.0 to 16.0
			4: begin
				k = $urandom_range(2, 181);                       // exact squares
				v = (k * k) << 16;
			end
			5: case ($urandom_range(0, 3))
				0: v = 32'd0;
				1: v = ONE_Q16;
				2: v = ONE_Q16 - 1;
				default: v = ONE_Q16 + 1;
			endcase
			default: v = {1'b0, 31'($urandom)};
		endcase
		return v;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_tolerance();
		case ($urandom_range(0, 6))
			0: return 31'd1;
			1: return 31'($urandom_range(1, 255));
			2: return TOL_RESET;
			3: return 31'($urandom);
			4: return 31'h7FFF_FFFF;
			5: return 31'($urandom_range(256, 32'h0004_0000));
			default: return $urandom_range(0, 3) == 0 ? 31'd0 : 31'd66;
		endcase
	endfunction

	// Iteration cap; upper data bits carry junk the register must ignore
	function automatic logic [CFG_DATA_W-1:0] pick_cap();
		logic [ITER_W-1:0] cap;
		case ($urandom_range(0, 7))
			0: cap = '0;
			1, 2: cap = 6'($urandom_range(1, 8));
			6: cap = 6'd63;
			7: cap = 6'($urandom_range(41, 62));
			default: cap = 6'($urandom_range(9, 40));
		endcase
		return {25'($urandom), cap};
	endfunction

	// Bursts of random length separated by random gaps
	task automatic run_random(input int unsigned count);
		int unsigned sent;
		int unsigned burst;
		int unsigned gap;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 12);
			for (int i = 0; i < burst && sent < count; i++) begin
				send_operand(pick_operand());
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_TOLERANCE;
		cfg_data        = '0;
		req_if.valid    = 1'b0;
		req_if.value_in = '0;
		res_if.ready    = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: direct answers, sign extremes, both sides of 1.0
		send_operand(32'd0);
		send_operand(ONE_Q16);
		send_operand(32'hFFFF_FFFF);
		send_operand(32'h8000_0000);
		send_operand(32'h7FFF_FFFF);
		send_operand(32'h0000_0001);
		send_operand(ONE_Q16 - 1);
		send_operand(ONE_Q16 + 1);
		send_operand(32'h0002_0000);
		send_operand(32'h0009_0000);
		send_operand(32'h0000_4000);
		drain();

		// Zero tolerance wins over the direct answers, but not over the sign
		write_reg(REG_TOLERANCE, 31'd0);
		send_operand(32'd0);
		send_operand(ONE_Q16);
		send_operand(32'h0002_0000);
		send_operand(32'hFFFF_0000);
		drain();

		// Zero cap: untested starting midpoint, saturated when too wide
		write_reg(REG_TOLERANCE, TOL_RESET);
		write_reg(REG_MAX_ITER, 31'd0);
		send_operand(32'h0002_0000);
		send_operand(32'h0000_8000);
		send_operand(32'h7FFF_FFFF);
		drain();

		write_reg(REG_MAX_ITER, 31'd1);
		send_operand(32'h7FFF_FFFF);
		send_operand(32'h0000_8000);
		drain();

		// Tightest tolerance with the full cap: the interval can stall, and then the cap ends it
		write_reg(REG_TOLERANCE, 31'd1);
		write_reg(REG_MAX_ITER, 31'd63);
		send_operand(32'h0000_0001);
		send_operand(32'h7FFF_FFFF);
		drain();

		// Loosest tolerance
		write_reg(REG_TOLERANCE, 31'h7FFF_FFFF);
		send_operand(32'h0005_0000);
		send_operand(32'h7FFF_FFFF);
		drain();

		// Random phases, each under fresh register settings
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_TOLERANCE, pick_tolerance());
			write_reg(REG_MAX_ITER, pick_cap());
			run_random(94);
			drain();
		end

		// Tail: idle wait for stray results
		repeat (20) @(posedge clk);
		if (roots.mismatches == 0 && roots.outstanding() == 0) begin
			$display("bisection_square_root: match");
		end else begin
			$display("bisection_square_root: mismatch");
		end
		$finish;
	end

	// Watchdog, several times the slowest legal run
	initial begin
		#40ms;
		$display("bisection_square_root: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/bsr_pkg.sv
rtl/core/bsr_if.sv
rtl/core/bsr_squarer.sv
rtl/core/bisection_square_root.sv
rtl/core/bsr_checker.sv
test/tb_bisection_square_root.sv
